// ----- design/vptw_pkg.sv -----
// shared types and constants for the vertex projection block
package vptw_pkg;

  localparam int VP_W = 13;

  typedef enum logic [1:0] {
    OP_LOAD_MV   = 2'd0,
    OP_LOAD_PROJ = 2'd1,
    OP_PROJECT   = 2'd2,
    OP_UNUSED    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    REG_VP_X = 2'd0,
    REG_VP_Y = 2'd1,
    REG_VP_W = 2'd2,
    REG_VP_H = 2'd3
  } reg_idx_t;

  // commands from controller to datapath
  typedef struct packed {
    logic       load_pt;    // capture point
    logic       acc_clr;    // clear accumulator
    logic       mac;        // multiply-accumulate one term
    logic       sel_proj;   // matrix select: 0 model-view, 1 projection
    logic [1:0] row;
    logic [1:0] col;
    logic       store_row;  // finish dot product into vector reg
    logic       swap_vec;   // input vector <= eye result for second pass
    logic       div_start;
    logic       div_sel_y;  // divide numerator y
    logic       map_x;      // viewport map result of divider to x
    logic       map_y;
  } vptw_cmd_t;

  typedef struct packed {
    logic div_done;
    logic w_zero;
  } vptw_sts_t;

endpackage

// ----- design/vertex_project_to_window_top.sv -----
// top level: apb viewport registers, controller and datapath
// Q16.16 by default: point result valid after two matrix passes on one shared multiplier,
// then two serial divides (none when w is zero) one quotient bit per cycle; next word
// taken as the result leaves
// rst_n synchronous active low: matrices to identity, viewport to 0,0,900,600
// the result word is held in output registers until out_ready; load words give no result
module vertex_project_to_window_top #(
  parameter int WORD_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [1:0]                   in_operation,
  input  logic [3:0]                   in_entry_index,
  input  logic signed [WORD_WIDTH-1:0] in_entry_value,
  input  logic signed [WORD_WIDTH-1:0] in_point_x,
  input  logic signed [WORD_WIDTH-1:0] in_point_y,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [WORD_WIDTH-1:0] out_window_x,
  output logic signed [WORD_WIDTH-1:0] out_window_y,
  output logic                         out_ok,
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [3:0]                   cfg_paddr,
  input  logic [31:0]                  cfg_pwdata,
  output logic [31:0]                  cfg_prdata,
  output logic                         cfg_pready
);
  logic [vptw_pkg::VP_W-1:0] vp_x_r, vp_y_r, vp_w_r, vp_h_r;
  vptw_pkg::vptw_cmd_t cmd;
  vptw_pkg::vptw_sts_t sts;
  logic wr_mv, wr_proj, ok_i;
  logic signed [WORD_WIDTH-1:0] wx, wy;
  logic cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vp_x_r <= '0; vp_y_r <= '0;
      vp_w_r <= vptw_pkg::VP_W'(900); vp_h_r <= vptw_pkg::VP_W'(600);
    end else if (cfg_wr && cfg_paddr[1:0] == 2'b00) begin
      case (cfg_paddr[3:2])
        vptw_pkg::REG_VP_X: vp_x_r <= cfg_pwdata[vptw_pkg::VP_W-1:0];
        vptw_pkg::REG_VP_Y: vp_y_r <= cfg_pwdata[vptw_pkg::VP_W-1:0];
        vptw_pkg::REG_VP_W: vp_w_r <= cfg_pwdata[vptw_pkg::VP_W-1:0];
        vptw_pkg::REG_VP_H: vp_h_r <= cfg_pwdata[vptw_pkg::VP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[3:2])
      vptw_pkg::REG_VP_X: cfg_prdata = 32'(vp_x_r);
      vptw_pkg::REG_VP_Y: cfg_prdata = 32'(vp_y_r);
      vptw_pkg::REG_VP_W: cfg_prdata = 32'(vp_w_r);
      vptw_pkg::REG_VP_H: cfg_prdata = 32'(vp_h_r);
      default:            cfg_prdata = '0;
    endcase
  end

  vptw_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_operation (in_operation),
    .wr_mv        (wr_mv),
    .wr_proj      (wr_proj),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .ok           (ok_i),
    .cmd          (cmd),
    .sts          (sts)
  );

  vptw_datapath #(.WORD_WIDTH(WORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .sts     (sts),
    .wr_mv   (wr_mv),
    .wr_proj (wr_proj),
    .wr_idx  (in_entry_index),
    .wr_val  (in_entry_value),
    .pt_x    (in_point_x),
    .pt_y    (in_point_y),
    .vp_x    (vp_x_r),
    .vp_y    (vp_y_r),
    .vp_w    (vp_w_r),
    .vp_h    (vp_h_r),
    .win_x   (wx),
    .win_y   (wy)
  );

  assign out_ok       = ok_i;
  assign out_window_x = ok_i ? wx : '0;
  assign out_window_y = ok_i ? wy : '0;

  a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_operation != vptw_pkg::OP_PROJECT && !out_valid)
      |=> !out_valid)
    else $error("load word produced a result");

  a_zero_coords: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ok) |-> (out_window_x == '0 && out_window_y == '0))
    else $error("failed projection with nonzero coordinates");

  a_no_mv_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_mv || wr_proj) |-> in_ready)
    else $error("matrix write outside accept");
endmodule

// ----- design/vptw_div.sv -----
// serial restoring divider for the perspective divide, one quotient bit per cycle
module vptw_div #(
  parameter int WORD_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic signed [WORD_WIDTH-1:0] num,
  input  logic signed [WORD_WIDTH-1:0] den,
  output logic                         done,
  output logic signed [WORD_WIDTH-1:0] quot
);
  localparam int NW = WORD_WIDTH + FRAC_BITS + 1;   // numerator bits incl rounding
  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0]         num_r, num_nxt;
  logic [WORD_WIDTH:0]   den_r, den_nxt;
  logic [WORD_WIDTH+1:0] rem_r, rem_nxt;
  logic [NW-1:0]         q_r, q_nxt;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic                  busy_r, busy_nxt;
  logic                  neg_r, neg_nxt;
  logic                  done_r, done_nxt;
  logic signed [WORD_WIDTH-1:0] quot_r, quot_nxt;

  logic [WORD_WIDTH:0]   nmag, dmag;
  logic [WORD_WIDTH+1:0] trial, sub;
  logic [NW:0]           qr;
  logic [NW+1:0]         qs;

  always_comb begin
    nmag = num[WORD_WIDTH-1] ? -{num[WORD_WIDTH-1], num} : {1'b0, num};
    dmag = den[WORD_WIDTH-1] ? -{den[WORD_WIDTH-1], den} : {1'b0, den};
    trial = {rem_r[WORD_WIDTH:0], num_r[NW-1]};
    sub   = trial - {1'b0, den_r};
    // quotient has one extra bit; round half away from zero
    qr = ({1'b0, q_r} + {{NW{1'b0}}, 1'b1}) >> 1;
    qs = neg_r ? -{1'b0, qr} : {1'b0, qr};
  end

  always_comb begin
    num_nxt = num_r; den_nxt = den_r; rem_nxt = rem_r; q_nxt = q_r;
    cnt_nxt = cnt_r; busy_nxt = busy_r; neg_nxt = neg_r;
    done_nxt = 1'b0; quot_nxt = quot_r;
    if (start) begin
      // magnitude never exceeds 2^(WORD_WIDTH-1), so its top bit is dropped
      num_nxt  = {nmag[WORD_WIDTH-1:0], {(FRAC_BITS+1){1'b0}}};
      den_nxt  = dmag;
      rem_nxt  = '0;
      q_nxt    = '0;
      cnt_nxt  = CW'(NW);
      busy_nxt = 1'b1;
      neg_nxt  = num[WORD_WIDTH-1] ^ den[WORD_WIDTH-1];
    end else if (busy_r) begin
      num_nxt = num_r << 1;
      if (!sub[WORD_WIDTH+1]) begin
        rem_nxt = sub;
        q_nxt   = {q_r[NW-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        q_nxt   = {q_r[NW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end else begin
      // saturate the finished quotient
      if (!qs[NW+1] && (qs[NW:WORD_WIDTH-1] != '0))
        quot_nxt = {1'b0, {(WORD_WIDTH-1){1'b1}}};
      else if (qs[NW+1] && (qs[NW:WORD_WIDTH-1] != '1))
        quot_nxt = {1'b1, {(WORD_WIDTH-1){1'b0}}};
      else
        quot_nxt = qs[WORD_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    num_r <= num_nxt; den_r <= den_nxt; rem_r <= rem_nxt; q_r <= q_nxt;
    neg_r <= neg_nxt; quot_r <= quot_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0; done_r <= 1'b0; cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt; done_r <= done_nxt; cnt_r <= cnt_nxt;
    end
  end

  // quotient register updates the cycle after the last step
  assign done = done_r;
  assign quot = quot_r;
endmodule

// ----- design/vptw_datapath.sv -----
// matrix stores, shared multiply-accumulate, viewport map and divider
module vptw_datapath #(
  parameter int WORD_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  vptw_pkg::vptw_cmd_t          cmd,
  output vptw_pkg::vptw_sts_t          sts,
  input  logic                         wr_mv,
  input  logic                         wr_proj,
  input  logic [3:0]                   wr_idx,
  input  logic signed [WORD_WIDTH-1:0] wr_val,
  input  logic signed [WORD_WIDTH-1:0] pt_x,
  input  logic signed [WORD_WIDTH-1:0] pt_y,
  input  logic [vptw_pkg::VP_W-1:0]    vp_x,
  input  logic [vptw_pkg::VP_W-1:0]    vp_y,
  input  logic [vptw_pkg::VP_W-1:0]    vp_w,
  input  logic [vptw_pkg::VP_W-1:0]    vp_h,
  output logic signed [WORD_WIDTH-1:0] win_x,
  output logic signed [WORD_WIDTH-1:0] win_y
);
  localparam int PW = 2 * WORD_WIDTH;
  localparam int AW = PW + 3;
  localparam int MW = WORD_WIDTH + 2 + vptw_pkg::VP_W + 1;
  localparam logic signed [WORD_WIDTH-1:0] ONE_Q = WORD_WIDTH'(1) << FRAC_BITS;
  localparam logic signed [WORD_WIDTH-1:0] WMAX = {1'b0, {(WORD_WIDTH-1){1'b1}}};
  localparam logic signed [WORD_WIDTH-1:0] WMIN = {1'b1, {(WORD_WIDTH-1){1'b0}}};

  logic signed [WORD_WIDTH-1:0] mv_r [16];
  logic signed [WORD_WIDTH-1:0] pj_r [16];
  logic signed [WORD_WIDTH-1:0] vin_r [4];
  logic signed [WORD_WIDTH-1:0] vout_r [4];
  logic signed [AW-1:0]         acc_r;
  logic signed [PW-1:0]         prod_r;
  logic                         prod_v_r;
  logic signed [WORD_WIDTH-1:0] win_x_r, win_y_r;

  logic signed [WORD_WIDTH-1:0] m_op, v_op, dot_sat, ndc, mapped;
  logic signed [AW-1:0]         acc_rnd, acc_sh;
  logic signed [MW-1:0]         t_prod, m_sum;
  logic [3:0]                   midx;
  logic                         dv_done;
  logic signed [WORD_WIDTH-1:0] dv_q;
  logic [vptw_pkg::VP_W-1:0]    sz, org;

  always_comb begin
    midx = {cmd.col, cmd.row};
    m_op = cmd.sel_proj ? pj_r[midx] : mv_r[midx];
    v_op = vin_r[cmd.col];
    // ties toward +inf: add half then floor
    acc_rnd = acc_r + (AW'(1) <<< (FRAC_BITS - 1));
    acc_sh  = acc_rnd >>> FRAC_BITS;
    if (acc_sh > AW'(WMAX))      dot_sat = WMAX;
    else if (acc_sh < AW'(WMIN)) dot_sat = WMIN;
    else                         dot_sat = acc_sh[WORD_WIDTH-1:0];
  end

  // identity reset for the matrices
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 16; i++) begin
        mv_r[i] <= ((i >> 2) == (i & 3)) ? ONE_Q : '0;
        pj_r[i] <= ((i >> 2) == (i & 3)) ? ONE_Q : '0;
      end
    end else begin
      if (wr_mv)   mv_r[wr_idx] <= wr_val;
      if (wr_proj) pj_r[wr_idx] <= wr_val;
    end
  end

  // product registered before accumulation
  always_ff @(posedge clk) begin
    prod_r <= PW'(m_op) * PW'(v_op);
    if (!rst_n) prod_v_r <= 1'b0;
    else        prod_v_r <= cmd.mac;
    if (cmd.acc_clr)    acc_r <= '0;
    else if (prod_v_r)  acc_r <= acc_r + AW'(prod_r);
    if (cmd.load_pt) begin
      vin_r[0] <= pt_x; vin_r[1] <= pt_y; vin_r[2] <= '0; vin_r[3] <= ONE_Q;
    end else if (cmd.swap_vec) begin
      for (int i = 0; i < 4; i++) vin_r[i] <= vout_r[i];
    end
    if (cmd.store_row) vout_r[cmd.row] <= dot_sat;
    if (cmd.map_x) win_x_r <= mapped;
    if (cmd.map_y) win_y_r <= mapped;
  end

  vptw_div #(.WORD_WIDTH(WORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (cmd.div_sel_y ? vout_r[1] : vout_r[0]),
    .den   (vout_r[3]),
    .done  (dv_done),
    .quot  (dv_q)
  );

  always_comb begin
    ndc = dv_q;
    sz  = cmd.map_y ? vp_h : vp_w;
    org = cmd.map_y ? vp_y : vp_x;
    t_prod = (MW'(ONE_Q) + MW'(ndc)) * MW'($signed({1'b0, sz}));
    m_sum  = (MW'($signed({1'b0, org})) <<< FRAC_BITS) + (t_prod >>> 1);
    if (m_sum > MW'(WMAX))      mapped = WMAX;
    else if (m_sum < MW'(WMIN)) mapped = WMIN;
    else                        mapped = m_sum[WORD_WIDTH-1:0];
  end

  assign sts.div_done = dv_done;
  assign sts.w_zero   = (vout_r[3] == '0);
  assign win_x = win_x_r;
  assign win_y = win_y_r;
endmodule

// ----- design/vptw_ctrl.sv -----
// sequencer for load, two matrix passes, divides and output word
module vptw_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          in_operation,
  output logic                wr_mv,
  output logic                wr_proj,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                ok,
  output vptw_pkg::vptw_cmd_t cmd,
  input  vptw_pkg::vptw_sts_t sts
);
  typedef enum logic [3:0] {
    S_IDLE, S_MAC, S_DRAIN, S_STORE, S_DIVX, S_WAITX, S_MAPX,
    S_DIVY, S_WAITY, S_MAPY, S_OUT
  } state_t;

  state_t     state_r, state_nxt;
  logic       pass_r, pass_nxt;
  logic [1:0] row_r, row_nxt, col_r, col_nxt;
  logic       ok_r, ok_nxt;
  logic       acc_go;
  logic       accept;

  assign in_ready = (state_r == S_IDLE) || (state_r == S_OUT && out_ready);
  assign accept   = in_valid && in_ready;
  assign wr_mv    = accept && (in_operation == vptw_pkg::OP_LOAD_MV);
  assign wr_proj  = accept && (in_operation == vptw_pkg::OP_LOAD_PROJ);
  assign acc_go   = accept && (in_operation == vptw_pkg::OP_PROJECT);

  always_comb begin
    state_nxt = state_r; pass_nxt = pass_r; row_nxt = row_r; col_nxt = col_r;
    ok_nxt = ok_r;
    cmd = '0;
    cmd.sel_proj = pass_r;
    cmd.row = row_r;
    cmd.col = col_r;
    case (state_r)
      S_IDLE, S_OUT: begin
        if (state_r == S_OUT && out_ready) state_nxt = S_IDLE;
        if (acc_go) begin
          cmd.load_pt = 1'b1;
          cmd.acc_clr = 1'b1;
          pass_nxt = 1'b0; row_nxt = '0; col_nxt = '0;
          state_nxt = S_MAC;
        end
      end
      S_MAC: begin
        cmd.mac = 1'b1;
        col_nxt = col_r + 2'd1;
        if (col_r == 2'd3) state_nxt = S_DRAIN;
      end
      S_DRAIN: state_nxt = S_STORE;   // last product lands in accumulator
      S_STORE: begin
        cmd.store_row = 1'b1;
        cmd.acc_clr   = 1'b1;
        row_nxt = row_r + 2'd1;
        state_nxt = S_MAC;
        if (row_r == 2'd3) begin
          if (!pass_r) begin
            pass_nxt = 1'b1;
            cmd.swap_vec = 1'b0;
            state_nxt = S_DIVX;  // overridden below to S_DIVY, which does the swap
          end else begin
            state_nxt = S_DIVX;
          end
        end
      end
      S_DIVX: begin
        if (!pass_r) begin
          state_nxt = S_MAC;
        end else if (cmd.sel_proj && row_r == 2'd0 && col_r == 2'd0 && ok_r) begin
          state_nxt = S_WAITX;
        end
        // handled via pass flag: see below
      end
      default: ;
    endcase
    // second pass entry and divide sequencing
    case (state_r)
      S_STORE: if (row_r == 2'd3 && !pass_r) state_nxt = S_DIVY;
      default: ;
    endcase
    case (state_r)
      S_DIVY: begin
        if (!ok_r) begin
          // first pass finished: swap vector and run projection pass
          cmd.swap_vec = 1'b1;
          ok_nxt = 1'b1;
          state_nxt = S_MAC;
        end else if (sts.w_zero) begin
          ok_nxt = 1'b0;
          state_nxt = S_MAPY;
        end else begin
          cmd.div_start = 1'b1;
          state_nxt = S_WAITX;
        end
      end
      S_DIVX: begin
        if (sts.w_zero) begin
          ok_nxt = 1'b0;
          state_nxt = S_MAPY;
        end else begin
          cmd.div_start = 1'b1;
          state_nxt = S_WAITX;
        end
      end
      S_WAITX: if (sts.div_done) state_nxt = S_MAPX;
      S_MAPX: begin
        cmd.map_x = 1'b1;
        cmd.div_sel_y = 1'b1;
        cmd.div_start = 1'b1;
        state_nxt = S_WAITY;
      end
      S_WAITY: begin
        cmd.div_sel_y = 1'b1;
        if (sts.div_done) state_nxt = S_MAPY;
      end
      S_MAPY: begin
        if (ok_r) begin
          cmd.map_y = 1'b1;
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_OUT;
        end
      end
      default: ;
    endcase
    if (acc_go) ok_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; pass_r <= 1'b0; row_r <= '0; col_r <= '0; ok_r <= 1'b0;
    end else begin
      state_r <= state_nxt; pass_r <= pass_nxt; row_r <= row_nxt;
      col_r <= col_nxt; ok_r <= ok_nxt;
    end
  end

  assign out_valid = (state_r == S_OUT);
  assign ok = ok_r;
endmodule

// ----- tb/sv/tb.sv -----
// self-checking testbench for vertex_project_to_window_top
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint WMAX = 64'sd2147483647;
  localparam longint WMIN = -64'sd2147483648;
  localparam longint ONE_Q = 64'sd65536;
  localparam int CYCLE_LIMIT = 2000000;

  typedef struct {
    logic signed [31:0] wx;
    logic signed [31:0] wy;
    logic               ok;
  } window_t;

  class projection_scoreboard;
    longint mv[16];
    longint pj[16];
    longint vpx, vpy, vpw, vph;
    window_t pending[$];
    int errors;

    function void reset_state();
      for (int i = 0; i < 16; i++) begin
        mv[i] = ((i >> 2) == (i & 3)) ? ONE_Q : 0;
        pj[i] = mv[i];
      end
      vpx = 0; vpy = 0; vpw = 900; vph = 600;
      errors = 0;
    endfunction

    function void set_viewport(vptw_pkg::reg_idx_t r, logic [12:0] v);
      case (r)
        vptw_pkg::REG_VP_X: vpx = v;
        vptw_pkg::REG_VP_Y: vpy = v;
        vptw_pkg::REG_VP_W: vpw = v;
        vptw_pkg::REG_VP_H: vph = v;
        default: ;
      endcase
    endfunction

    function longint clamp(longint v);
      if (v > WMAX) return WMAX;
      if (v < WMIN) return WMIN;
      return v;
    endfunction

    // sum of four products, rounded half up, saturated
    function longint dot_row(bit proj, int r, longint v[4]);
      logic signed [66:0] acc;
      acc = 0;
      for (int k = 0; k < 4; k++)
        acc += 67'(proj ? pj[k*4+r] : mv[k*4+r]) * 67'(v[k]);
      acc = (acc + 67'sd32768) >>> 16;
      return clamp(longint'(acc));
    endfunction

    function longint ndc_div(longint c, longint w);
      bit neg;
      longint cm, wm, q;
      neg = (c < 0) != (w < 0);
      cm = c < 0 ? -c : c;
      wm = w < 0 ? -w : w;
      q = ((cm << 16) + wm / 2) / wm;
      return clamp(neg ? -q : q);
    endfunction

    function longint vp_map(longint ndc, longint org, longint sz);
      return clamp((org << 16) + (((ONE_Q + ndc) * sz) >>> 1));
    endfunction

    function void note_input(vptw_pkg::op_t op, logic [3:0] idx, logic signed [31:0] val,
                             logic signed [31:0] px, logic signed [31:0] py);
      longint obj[4], eye[4], clip[4];
      window_t w;
      case (op)
        vptw_pkg::OP_LOAD_MV: mv[idx] = val;
        vptw_pkg::OP_LOAD_PROJ: pj[idx] = val;
        vptw_pkg::OP_PROJECT: begin
          obj[0] = px; obj[1] = py; obj[2] = 0; obj[3] = ONE_Q;
          for (int r = 0; r < 4; r++) eye[r] = dot_row(1'b0, r, obj);
          for (int r = 0; r < 4; r++) clip[r] = dot_row(1'b1, r, eye);
          w.wx = 0; w.wy = 0; w.ok = 0;
          if (clip[3] != 0) begin
            w.wx = 32'(vp_map(ndc_div(clip[0], clip[3]), vpx, vpw));
            w.wy = 32'(vp_map(ndc_div(clip[1], clip[3]), vpy, vph));
            w.ok = 1;
          end
          pending.push_back(w);
        end
        default: ;
      endcase
    endfunction

    task report(string what, longint got, longint exp);
      $display("mismatch %s: got %0d expected %0d", what, got, exp);
      errors++;
    endtask

    task check_result(logic signed [31:0] wx, logic signed [31:0] wy, logic ok);
      window_t e;
      if (pending.size() == 0) begin
        report("unexpected word", 0, 0);
        return;
      end
      e = pending.pop_front();
      if (wx !== e.wx) report("window_x", wx, e.wx);
      if (wy !== e.wy) report("window_y", wy, e.wy);
      if (ok !== e.ok) report("ok", ok, e.ok);
    endtask
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_ready;
  logic [1:0] in_operation = 0;
  logic [3:0] in_entry_index = 0;
  logic signed [31:0] in_entry_value = 0, in_point_x = 0, in_point_y = 0;
  logic out_valid;
  logic out_ready = 0;
  logic signed [31:0] out_window_x, out_window_y;
  logic out_ok;
  logic cfg_psel = 0, cfg_penable = 0, cfg_pwrite = 0;
  logic [3:0] cfg_paddr = 0;
  logic [31:0] cfg_pwdata = 0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  projection_scoreboard sb;
  int cycles = 0;
  bit quiet = 0;       // no idling in the last part
  bit hold_off = 0;    // long receiver stall request

  always #1 clk = ~clk;

  vertex_project_to_window_top uut (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("vertex_project_to_window_top regression: fail");
      $finish;
    end
  end

  // result side: random stall bursts, a long stall on request
  initial begin : receiver
    int n;
    @(posedge clk iff rst_n);
    forever begin
      if (hold_off) begin
        out_ready <= 0;
        repeat (600) @(posedge clk);
        hold_off = 0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_ready <= 0;
        n = $urandom_range(1, 10);
        repeat (n) @(posedge clk);
      end else begin
        out_ready <= 1;
        n = $urandom_range(1, 20);
        repeat (n) @(posedge clk);
      end
    end
  end

  always @(posedge clk)
    if (rst_n && out_valid && out_ready)
      sb.check_result(out_window_x, out_window_y, out_ok);

  task send_word(vptw_pkg::op_t op, logic [3:0] idx, logic signed [31:0] val,
                 logic signed [31:0] px, logic signed [31:0] py);
    int gap;
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_valid <= 0;
      gap = $urandom_range(1, 10);
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    in_operation <= op;
    in_entry_index <= idx;
    in_entry_value <= val;
    in_point_x <= px;
    in_point_y <= py;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_input(op, idx, val, px, py);
  endtask

  task go_idle();
    in_valid <= 0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task write_reg(vptw_pkg::reg_idx_t r, logic [12:0] v);
    cfg_psel <= 1; cfg_pwrite <= 1; cfg_penable <= 0;
    cfg_paddr <= {r, 2'b00}; cfg_pwdata <= 32'(v);
    @(posedge clk);
    cfg_penable <= 1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    sb.set_viewport(r, v);
    cfg_psel <= 0; cfg_penable <= 0; cfg_pwrite <= 0;
    @(posedge clk);
  endtask

  task set_view(logic [12:0] x, logic [12:0] y, logic [12:0] w, logic [12:0] h);
    write_reg(vptw_pkg::REG_VP_X, x);
    write_reg(vptw_pkg::REG_VP_Y, y);
    write_reg(vptw_pkg::REG_VP_W, w);
    write_reg(vptw_pkg::REG_VP_H, h);
  endtask

  function logic signed [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return $signed($urandom_range(0, 262143)) - 32'sd131072;
      3: return 0;
      default: return $urandom;
    endcase
  endfunction

  // modest matrix entries keep most points inside range
  function logic signed [31:0] entry_word();
    if ($urandom_range(0, 9) == 0) return rand_word();
    return $signed($urandom_range(0, 524287)) - 32'sd262144;
  endfunction

  task random_phase(int count);
    int k;
    vptw_pkg::op_t op;
    for (k = 0; k < count; k++) begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3: op = vptw_pkg::OP_LOAD_MV;
        4, 5, 6, 7: op = vptw_pkg::OP_LOAD_PROJ;
        8: op = vptw_pkg::OP_UNUSED;
        default: op = vptw_pkg::OP_PROJECT;
      endcase
      send_word(op, 4'($urandom), entry_word(), rand_word(), rand_word());
    end
  endtask

  initial begin : main
    sb = new();
    sb.reset_state();
    repeat (4) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: identity, extremes, unused code, zero w, zero-size viewport
    send_word(vptw_pkg::OP_PROJECT, 0, 0, 0, 0);
    send_word(vptw_pkg::OP_PROJECT, 0, 0, 32'sh7fffffff, 32'sh80000000);
    send_word(vptw_pkg::OP_PROJECT, 0, 0, 32'sh80000000, 32'sh7fffffff);
    send_word(vptw_pkg::OP_PROJECT, 0, 0, 32'sh00010000, -32'sh00010000);
    send_word(vptw_pkg::OP_UNUSED, 4'hf, 32'sh7fffffff, 1, 1);
    send_word(vptw_pkg::OP_LOAD_PROJ, 15, 0, 0, 0);
    send_word(vptw_pkg::OP_PROJECT, 0, 0, 32'sh00008000, 32'sh00008000);
    send_word(vptw_pkg::OP_LOAD_PROJ, 15, 32'sh00010000, -1, -1);
    send_word(vptw_pkg::OP_LOAD_PROJ, 11, 32'sh00008000, 0, 0);
    send_word(vptw_pkg::OP_LOAD_MV, 15, 32'sh80000000, 0, 0);
    send_word(vptw_pkg::OP_LOAD_MV, 0, 32'sh7fffffff, 0, 0);
    send_word(vptw_pkg::OP_PROJECT, 4'hf, -1, 32'sh00020000, 32'sh00030000);
    send_word(vptw_pkg::OP_PROJECT, 0, 0, -32'sh00000001, 32'sh00000001);
    send_word(vptw_pkg::OP_LOAD_MV, 15, 32'sh00010000, 0, 0);
    send_word(vptw_pkg::OP_LOAD_MV, 0, 32'sh00010000, 0, 0);
    send_word(vptw_pkg::OP_LOAD_PROJ, 11, 0, 0, 0);
    go_idle();
    set_view(0, 0, 0, 0);
    send_word(vptw_pkg::OP_PROJECT, 0, 0, 32'sh00004000, -32'sh00004000);
    go_idle();
    set_view(8191, 8191, 8191, 8191);
    send_word(vptw_pkg::OP_PROJECT, 0, 0, 32'sh00010000, 32'sh00010000);
    send_word(vptw_pkg::OP_PROJECT, 0, 0, -32'sh00010000, -32'sh00010000);
    send_word(vptw_pkg::OP_PROJECT, 0, 0, 32'sh7fffffff, 32'sh7fffffff);

    // long receiver stall while words keep coming
    hold_off = 1;
    random_phase(60);
    go_idle();
    set_view(10, 20, 1, 1);
    random_phase(400);
    go_idle();
    set_view(13'($urandom_range(0, 8191)), 13'($urandom_range(0, 8191)),
             13'($urandom_range(1, 8191)), 13'($urandom_range(1, 8191)));
    random_phase(400);
    go_idle();
    set_view(0, 0, 900, 600);
    random_phase(400);
    quiet = 1;
    random_phase(370);
    go_idle();

    if (sb.errors == 0)
      $display("vertex_project_to_window_top regression: pass");
    else
      $display("vertex_project_to_window_top regression: fail");
    $finish;
  end
endmodule
